// ===== rtl/jtl_pkg.sv =====
package jtl_pkg;

  // Default position counter width
  localparam int POS_BITS_DEF = 32;

  // Result slots one byte can produce, and the most that are ever valid
  localparam int SLOTS    = 4;
  localparam int SLOT_MAX = 3;

  // Result queue
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

  // Result kinds
  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // Token kinds
  localparam logic [1:0] TK_LITERAL = 2'd0;
  localparam logic [1:0] TK_STRING  = 2'd1;
  localparam logic [1:0] TK_NUMBER  = 2'd2;
  localparam logic [1:0] TK_PUNCT   = 2'd3;

  // Error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_ESCAPE     = 4'd1;
  localparam logic [3:0] ERR_CONTROL    = 4'd2;
  localparam logic [3:0] ERR_UNTERM     = 4'd3;
  localparam logic [3:0] ERR_NUMBER     = 4'd4;
  localparam logic [3:0] ERR_LEAD_ZERO  = 4'd5;
  localparam logic [3:0] ERR_FRACTION   = 4'd6;
  localparam logic [3:0] ERR_EXPONENT   = 4'd7;
  localparam logic [3:0] ERR_UNEXPECTED = 4'd8;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  token_kind;
    logic [31:0] position;
    logic [31:0] token_length;
    logic [3:0]  error_code;
    logic [31:0] token_total;
    logic        run_end;
  } result_t;

  // Results of one byte, in order, each with its valid bit
  typedef struct packed {
    logic [SLOTS-1:0]          valid;
    result_t [SLOTS-1:0]       item;
  } push_t;

endpackage

// ===== rtl/jtl_if.sv =====
interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_doc;

  modport source (output valid, output data_byte, output end_of_doc, input ready);
  modport sink   (input valid, input data_byte, input end_of_doc, output ready);
endinterface

interface jtl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  token_kind;
  logic [31:0] position;
  logic [31:0] token_length;
  logic [3:0]  error_code;
  logic [31:0] token_total;
  logic        run_end;

  modport source (output valid, output result_kind, output token_kind, output position,
                  output token_length, output error_code, output token_total,
                  output run_end, input ready);
  modport sink   (input valid, input result_kind, input token_kind, input position,
                  input token_length, input error_code, input token_total,
                  input run_end, output ready);
endinterface

// ===== rtl/json_token_lexer.sv =====
// A byte is held in the input register until the result queue has room; its results are
//   then written to the queue, and the oldest queued word is shown on the output.
// Throughput: one byte per cycle while the result side takes one word per cycle; a byte
//   that yields several words holds input only when the 8-entry result queue runs short.
// Reset (rst, synchronous): clears the lexer state, the input register and the queue.
module json_token_lexer
  import jtl_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  jtl_in_if.sink     din,
  jtl_out_if.source  dout
);

  push_t push;
  logic  room;

  jtl_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .room (room),
    .push (push)
  );

  jtl_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .dout (dout)
  );

endmodule

// ===== rtl/jtl_core.sv =====
module jtl_core
  import jtl_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  jtl_in_if.sink        din,
  input  logic          room,
  output push_t         push
);

  localparam int WIDE = (POS_BITS > 32) ? POS_BITS : 32;

  typedef enum logic [3:0] {
    M_IDLE, M_LIT, M_STR, M_ESC, M_HEX, M_NEG, M_ZERO, M_INT, M_DOT,
    M_FRAC, M_E, M_ESIGN, M_EXP
  } mode_t;

  // Literal spelling: 0 true, 1 false, 2 null
  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] k);
    logic [7:0] r;
    r = 8'h00;
    unique case (w)
      2'd0: unique case (k)
        3'd0: r = "t"; 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e";
        default: r = 8'h00;
      endcase
      2'd1: unique case (k)
        3'd0: r = "f"; 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s"; 3'd4: r = "e";
        default: r = 8'h00;
      endcase
      2'd2: unique case (k)
        3'd0: r = "n"; 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l";
        default: r = 8'h00;
      endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] w);
    return (w == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [31:0] to_out(input logic [POS_BITS-1:0] v);
    logic [WIDE-1:0] x;
    x = WIDE'(v);
    return x[31:0];
  endfunction

  function automatic result_t mk_token(input logic [1:0] tk, input logic [POS_BITS-1:0] at,
                                       input logic [POS_BITS-1:0] len);
    result_t r;
    r = '0;
    r.result_kind  = RK_TOKEN;
    r.token_kind   = tk;
    r.position     = to_out(at);
    r.token_length = to_out(len);
    return r;
  endfunction

  function automatic result_t mk_fail(input logic [3:0] code, input logic [POS_BITS-1:0] at);
    result_t r;
    r = '0;
    r.result_kind = RK_ERROR;
    r.position    = to_out(at);
    r.error_code  = code;
    return r;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  // Input register
  logic        in_valid;
  logic [7:0]  c;
  logic        last;

  // Lexer state
  mode_t               mode, mode_next;
  logic [2:0]          hex_left, hex_left_next;
  logic [1:0]          literal_which, literal_which_next;
  logic [2:0]          literal_index, literal_index_next;
  logic [POS_BITS-1:0] byte_position;
  logic [POS_BITS-1:0] token_begin, token_begin_next;
  logic [31:0]         tokens_seen, tokens_seen_next;
  logic                failed, failed_next;

  logic                advance;
  logic [POS_BITS-1:0] pos_inc;
  logic [SLOTS-1:0]    slot_valid;
  result_t             slot [SLOTS];
  logic                idle_run;
  logic                ends;
  logic [1:0]          w;
  logic [2:0]          kk;

  assign advance   = in_valid && room;
  assign din.ready = !in_valid || advance;
  assign pos_inc   = byte_position + POS_BITS'(1);

  // Lex one byte: slot 0 from the open token, slot 1 from a token start,
  // slot 2 from closing the document, slot 3 the done word
  always_comb begin
    mode_next          = mode;
    hex_left_next      = hex_left;
    literal_which_next = literal_which;
    literal_index_next = literal_index;
    token_begin_next   = token_begin;
    tokens_seen_next   = tokens_seen;
    failed_next        = failed;
    slot_valid         = '0;
    for (int i = 0; i < SLOTS; i++) slot[i] = '0;
    idle_run = 1'b0;
    ends     = 1'b0;
    w        = (literal_which == 2'd3) ? 2'd0 : literal_which;
    kk       = (literal_index >= 3'd6) ? (literal_index - 3'd6) : literal_index;

    if (!failed) begin
      unique case (mode)
        M_LIT: begin
          if (lit_char(w, kk) != c || kk >= lit_len(w)) begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_UNEXPECTED, token_begin);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end else begin
            literal_index_next = kk + 3'd1;
            if (kk + 3'd1 >= lit_len(w)) begin
              slot_valid[0] = 1'b1;
              slot[0]       = mk_token(TK_LITERAL, token_begin, POS_BITS'(lit_len(w)));
              mode_next     = M_IDLE;
            end
          end
        end
        M_STR: begin
          if (c == "\\") begin
            mode_next = M_ESC;
          end else if (c == "\"") begin
            slot_valid[0] = 1'b1;
            slot[0] = mk_token(TK_STRING, token_begin,
                               byte_position - token_begin - POS_BITS'(1));
            mode_next = M_IDLE;
          end else if (c < 8'h20) begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_CONTROL, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end
        end
        M_ESC: begin
          if (c == "u") begin
            hex_left_next = 3'd4;
            mode_next     = M_HEX;
          end else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                       c == "n" || c == "r" || c == "t") begin
            mode_next = M_STR;
          end else begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_ESCAPE, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end
        end
        M_HEX: begin
          if (!is_hex(c)) begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_ESCAPE, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end else begin
            hex_left_next = hex_left - 3'd1;
            if (hex_left_next == 3'd0) mode_next = M_STR;
          end
        end
        M_NEG: begin
          if (c == "0") mode_next = M_ZERO;
          else if (is_dig(c)) mode_next = M_INT;
          else begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_NUMBER, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end
        end
        M_ZERO: begin
          if (is_dig(c)) begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_LEAD_ZERO, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end else if (c == ".") mode_next = M_DOT;
          else if (c == "e" || c == "E") mode_next = M_E;
          else ends = 1'b1;
        end
        M_INT: begin
          if (is_dig(c)) mode_next = M_INT;
          else if (c == ".") mode_next = M_DOT;
          else if (c == "e" || c == "E") mode_next = M_E;
          else ends = 1'b1;
        end
        M_DOT: begin
          if (is_dig(c)) mode_next = M_FRAC;
          else begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_FRACTION, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end
        end
        M_FRAC: begin
          if (is_dig(c)) mode_next = M_FRAC;
          else if (c == "e" || c == "E") mode_next = M_E;
          else ends = 1'b1;
        end
        M_E: begin
          if (c == "+" || c == "-") mode_next = M_ESIGN;
          else if (is_dig(c)) mode_next = M_EXP;
          else begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_EXPONENT, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end
        end
        M_ESIGN: begin
          if (is_dig(c)) mode_next = M_EXP;
          else begin
            slot_valid[0] = 1'b1;
            slot[0]       = mk_fail(ERR_EXPONENT, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end
        end
        M_EXP: begin
          if (!is_dig(c)) ends = 1'b1;
        end
        M_IDLE: begin
          idle_run = 1'b1;
        end
        default: begin
          mode_next = M_IDLE;
          idle_run  = 1'b1;
        end
      endcase

      // Close a number on the byte after it, then lex that byte
      if (ends) begin
        slot_valid[0] = 1'b1;
        slot[0]       = mk_token(TK_NUMBER, token_begin, byte_position - token_begin);
        mode_next     = M_IDLE;
        idle_run      = 1'b1;
      end

      // Start a token, skip whitespace
      if (idle_run) begin
        if (c == " " || c == "\n" || c == "\r" || c == "\t") begin
          mode_next = M_IDLE;
        end else if (c == "{" || c == "}" || c == "[" || c == "]" || c == ":" ||
                     c == ",") begin
          slot_valid[1] = 1'b1;
          slot[1]       = mk_token(TK_PUNCT, byte_position, POS_BITS'(1));
        end else begin
          token_begin_next = byte_position;
          if (c == "t" || c == "f" || c == "n") begin
            literal_which_next = (c == "t") ? 2'd0 : ((c == "f") ? 2'd1 : 2'd2);
            literal_index_next = 3'd1;
            mode_next          = M_LIT;
          end else if (c == "\"") mode_next = M_STR;
          else if (c == "-") mode_next = M_NEG;
          else if (c == "0") mode_next = M_ZERO;
          else if (is_dig(c)) mode_next = M_INT;
          else begin
            slot_valid[1] = 1'b1;
            slot[1]       = mk_fail(ERR_UNEXPECTED, byte_position);
            failed_next   = 1'b1;
            mode_next     = M_IDLE;
          end
        end
      end

      // Close the document on its last byte
      if (last && !failed_next) begin
        unique case (mode_next)
          M_IDLE: ;
          M_LIT: begin
            slot_valid[2] = 1'b1;
            slot[2]       = mk_fail(ERR_UNEXPECTED, token_begin_next);
            failed_next   = 1'b1;
          end
          M_STR, M_ESC, M_HEX: begin
            slot_valid[2] = 1'b1;
            slot[2]       = mk_fail(ERR_UNTERM, token_begin_next);
            failed_next   = 1'b1;
          end
          M_NEG: begin
            slot_valid[2] = 1'b1;
            slot[2]       = mk_fail(ERR_NUMBER, pos_inc);
            failed_next   = 1'b1;
          end
          M_DOT: begin
            slot_valid[2] = 1'b1;
            slot[2]       = mk_fail(ERR_FRACTION, pos_inc);
            failed_next   = 1'b1;
          end
          M_E, M_ESIGN: begin
            slot_valid[2] = 1'b1;
            slot[2]       = mk_fail(ERR_EXPONENT, pos_inc);
            failed_next   = 1'b1;
          end
          default: begin
            slot_valid[2] = 1'b1;
            slot[2]       = mk_token(TK_NUMBER, token_begin_next, pos_inc - token_begin_next);
          end
        endcase
      end

      // Count tokens among the first three slots
      for (int i = 0; i < SLOT_MAX; i++) begin
        if (slot_valid[i] && slot[i].result_kind == RK_TOKEN)
          tokens_seen_next = tokens_seen_next + 32'd1;
      end

      if (last && !failed_next) begin
        slot_valid[3]     = 1'b1;
        slot[3]           = '0;
        slot[3].result_kind = RK_DONE;
        slot[3].position  = to_out(pos_inc);
        slot[3].token_total = tokens_seen_next;
      end
    end
  end

  // Mark the last word of the byte and hand the slots on
  always_comb begin
    push.valid = advance ? slot_valid : '0;
    for (int i = 0; i < SLOTS; i++) begin
      push.item[i] = slot[i];
      push.item[i].run_end = slot_valid[i] && ((slot_valid >> (i + 1)) == '0);
    end
  end

  // Hold the input word until the queue has room for its results
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (din.valid && din.ready) begin
      c    <= din.data_byte;
      last <= din.end_of_doc;
    end
  end

  // Advance the lexer state; the last byte restarts it
  always_ff @(posedge clk) begin
    if (rst || (advance && last)) begin
      mode          <= M_IDLE;
      hex_left      <= '0;
      literal_which <= '0;
      literal_index <= '0;
      byte_position <= '0;
      token_begin   <= '0;
      tokens_seen   <= '0;
      failed        <= 1'b0;
    end else if (advance) begin
      mode          <= mode_next;
      hex_left      <= hex_left_next;
      literal_which <= literal_which_next;
      literal_index <= literal_index_next;
      byte_position <= pos_inc;
      token_begin   <= token_begin_next;
      tokens_seen   <= tokens_seen_next;
      failed        <= failed_next;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (advance && last) |=> (byte_position == '0 && !failed && tokens_seen == '0))
    else $error("state not restarted after last byte");

  a_failed_idle: assert property (@(posedge clk) disable iff (rst)
    failed |-> (mode == M_IDLE))
    else $error("lexer not idle after error");

  a_slot_limit: assert property (@(posedge clk) disable iff (rst)
    advance |-> ($countones(slot_valid) <= SLOT_MAX))
    else $error("too many results for one byte");

endmodule

// ===== rtl/jtl_queue.sv =====
module jtl_queue
  import jtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       room,
  jtl_out_if.source  dout
);

  result_t             mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] head;
  logic [PTR_BITS-1:0] tail;
  logic [PTR_BITS:0]   count;
  logic [PTR_BITS-1:0] wr_idx [SLOTS];
  logic [2:0]          npush;
  logic                pop;

  assign pop  = dout.valid && dout.ready;
  assign room = count <= (PTR_BITS + 1)'(QUEUE_DEPTH - SLOT_MAX);

  // Pack the valid slots behind the tail in order
  always_comb begin
    npush = '0;
    for (int i = 0; i < SLOTS; i++) begin
      wr_idx[i] = tail + PTR_BITS'(npush);
      if (push.valid[i]) npush = npush + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (push.valid[i]) mem[wr_idx[i]] <= push.item[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_BITS'(npush);
      head  <= head + PTR_BITS'(pop);
      count <= count + (PTR_BITS + 1)'(npush) - (PTR_BITS + 1)'(pop);
    end
  end

  // Show the oldest word
  assign dout.valid        = count != '0;
  assign dout.result_kind  = mem[head].result_kind;
  assign dout.token_kind   = mem[head].token_kind;
  assign dout.position     = mem[head].position;
  assign dout.token_length = mem[head].token_length;
  assign dout.error_code   = mem[head].error_code;
  assign dout.token_total  = mem[head].token_total;
  assign dout.run_end      = mem[head].run_end;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_BITS + 1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) + (PTR_BITS + 1)'($past(npush))
                                - (PTR_BITS + 1)'($past(pop))))
    else $error("result queue count mismatch");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (tail - head) == count[PTR_BITS-1:0])
    else $error("result queue pointers out of step with count");

endmodule
